// ===== src/lmts_pkg.sv =====
// Package for the LCD mode timing sequencer: shared types, timing constants,
// register indexes and the mode encoding. No dependencies.

package lmts_pkg;

    // Timing thresholds in machine cycles, and line numbers.
    localparam logic [7:0] HBLANK_CYCLES      = 8'd51;
    localparam logic [7:0] VBLANK_LINE_CYCLES = 8'd114;
    localparam logic [7:0] OAM_CYCLES         = 8'd20;
    localparam logic [7:0] TRANSFER_CYCLES    = 8'd43;
    localparam logic [7:0] FIRST_VBLANK_LINE  = 8'd144;
    localparam logic [7:0] LINES_PER_FRAME    = 8'd154;
    localparam logic [7:0] LAST_LINE          = 8'd153;

    // Configuration register indexes.
    localparam logic [2:0] REG_DISPLAY_ENABLE = 3'd0;
    localparam logic [2:0] REG_HBLANK_IRQ_EN  = 3'd1;
    localparam logic [2:0] REG_VBLANK_IRQ_EN  = 3'd2;
    localparam logic [2:0] REG_OAM_IRQ_EN     = 3'd3;
    localparam logic [2:0] REG_MATCH_IRQ_EN   = 3'd4;
    localparam logic [2:0] REG_LINE_COMPARE   = 3'd5;

    // Mode codes as they appear on the output.
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // Internal one-hot mode state.
    typedef enum logic [3:0] {
        MS_HBLANK   = 4'b0001,
        MS_VBLANK   = 4'b0010,
        MS_OAM      = 4'b0100,
        MS_TRANSFER = 4'b1000
    } mode_state_t;

    // Configuration register contents.
    typedef struct packed {
        logic       display_enable;
        logic       hblank_irq_enable;
        logic       vblank_stat_irq_enable;
        logic       oam_irq_enable;
        logic       match_irq_enable;
        logic [7:0] line_compare;
    } lmts_cfg_t;

    // Timing state carried from one tick to the next.
    typedef struct packed {
        logic [7:0]  cycle_count;
        mode_state_t mode;
        logic [7:0]  line;
    } lmts_state_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0] disp_mode;
        logic [7:0] current_line;
        logic       line_match;
        logic       vblank_irq;
        logic       stat_irq;
        logic       draw_line;
    } lmts_result_t;

    // Map the one-hot mode state to the output mode code.
    function automatic logic [1:0] mode_code(input mode_state_t m);
        logic [1:0] code;
        unique case (m)
            MS_HBLANK:   code = MODE_HBLANK;
            MS_VBLANK:   code = MODE_VBLANK;
            MS_OAM:      code = MODE_OAM;
            MS_TRANSFER: code = MODE_TRANSFER;
            default:     code = MODE_HBLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== src/lcd_mode_timing_sequencer.sv =====
// Top level of the LCD mode timing sequencer: tick input register, timing
// state, result register and checks. Depends on lmts_pkg, lmts_cfg_regs, lmts_step.
//
// Usage:
// - Input channel (in_valid/in_ready, cycles): each transaction is one tick
//   carrying 0 to 15 machine cycles.
// - Output channel (out_valid/out_ready): one result transaction per tick
//   with the mode, line, coincidence flag, interrupt requests and draw pulse.
// - Configuration: cfg_we/cfg_index/cfg_data write one register per cycle,
//   with no wait; write only while no tick is in flight.
// The tick sits in the input register; once the result register is free or
// being emptied, the step logic updates the timing state and loads the result
// register. Throughput is one tick per cycle while the receiver takes results,
// set by the combinational add, compare and subtract on the cycle counter.
// When the receiver stalls, the result register holds and the input
// register still takes one more tick; after that in_ready drops until the
// result is taken.
// Reset clears all configuration registers, the cycle counter, the line
// and the mode (H-blank), and empties both registers.

module lcd_mode_timing_sequencer
    import lmts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] cycles,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] disp_mode,
    output logic [7:0] current_line,
    output logic       line_match,
    output logic       vblank_irq,
    output logic       stat_irq,
    output logic       draw_line
);

    lmts_cfg_t    cfg;
    lmts_state_t  state_reg;
    lmts_state_t  state_next;
    lmts_result_t result_next;
    lmts_result_t result_reg;
    logic [3:0]   cycles_reg;
    logic         in_valid_reg;
    logic         out_valid_reg;
    logic         advance;

    lmts_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lmts_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .cycles     (cycles_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The tick moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Control and timing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.cycle_count <= 8'd0;
            state_reg.mode        <= MS_HBLANK;
            state_reg.line        <= 8'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cycles_reg <= cycles;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign disp_mode    = result_reg.disp_mode;
    assign current_line = result_reg.current_line;
    assign line_match   = result_reg.line_match;
    assign vblank_irq   = result_reg.vblank_irq;
    assign stat_irq     = result_reg.stat_irq;
    assign draw_line    = result_reg.draw_line;

    // The line counter never leaves the frame.
    a_line_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line <= LAST_LINE)
        else $error("line counter beyond last line");

    // A draw pulse always comes with the switch to H-blank.
    a_draw_hblank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && draw_line) |-> (disp_mode == MODE_HBLANK))
        else $error("draw pulse outside H-blank");

    // V-blank request only on entering the first V-blank line.
    a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && vblank_irq) |->
            (disp_mode == MODE_VBLANK && current_line == FIRST_VBLANK_LINE))
        else $error("V-blank request away from first V-blank line");

    // With both registers full and the receiver stalled, no tick is taken.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("tick accepted while pipeline is full");

endmodule

// ===== src/lmts_cfg_regs.sv =====
// Configuration register file of the LCD mode timing sequencer.
// Depends on lmts_pkg for register indexes and the configuration struct.

module lmts_cfg_regs
    import lmts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output lmts_cfg_t  cfg
);

    lmts_cfg_t cfg_reg;
    lmts_cfg_t cfg_next;

    // Decode the write; indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DISPLAY_ENABLE: cfg_next.display_enable         = cfg_data[0];
                REG_HBLANK_IRQ_EN:  cfg_next.hblank_irq_enable      = cfg_data[0];
                REG_VBLANK_IRQ_EN:  cfg_next.vblank_stat_irq_enable = cfg_data[0];
                REG_OAM_IRQ_EN:     cfg_next.oam_irq_enable         = cfg_data[0];
                REG_MATCH_IRQ_EN:   cfg_next.match_irq_enable       = cfg_data[0];
                REG_LINE_COMPARE:   cfg_next.line_compare           = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // All registers reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lmts_step.sv =====
// Next-state and result logic for one tick of the LCD mode timing sequencer.
// Purely combinational; depends on lmts_pkg.

module lmts_step
    import lmts_pkg::*;
(
    input  lmts_cfg_t    cfg,
    input  lmts_state_t  state,
    input  logic [3:0]   cycles,
    output lmts_state_t  state_next,
    output lmts_result_t result
);

    logic [7:0]  count_sum;
    logic [7:0]  line_inc;
    logic [7:0]  count_new;
    logic [7:0]  line_new;
    mode_state_t mode_new;
    logic        vbl;
    logic        draw;
    logic        mode_stat;
    logic        match;

    assign count_sum = state.cycle_count + {4'b0000, cycles};
    assign line_inc  = state.line + 8'd1;

    // At most one mode or line transition per tick.
    always_comb
    begin
        count_new = count_sum;
        line_new  = state.line;
        mode_new  = state.mode;
        vbl       = 1'b0;
        draw      = 1'b0;
        mode_stat = 1'b0;
        unique case (state.mode)
            MS_HBLANK:
            begin
                if (count_sum >= HBLANK_CYCLES)
                begin
                    count_new = count_sum - HBLANK_CYCLES;
                    line_new  = line_inc;
                    if (line_inc == FIRST_VBLANK_LINE)
                    begin
                        mode_new  = MS_VBLANK;
                        vbl       = 1'b1;
                        mode_stat = cfg.vblank_stat_irq_enable;
                    end
                    else
                    begin
                        mode_new  = MS_OAM;
                        mode_stat = cfg.oam_irq_enable;
                    end
                end
            end
            MS_VBLANK:
            begin
                if (count_sum >= VBLANK_LINE_CYCLES)
                begin
                    count_new = count_sum - VBLANK_LINE_CYCLES;
                    line_new  = line_inc;
                    if (line_inc == LINES_PER_FRAME)
                    begin
                        line_new  = 8'd0;
                        mode_new  = MS_OAM;
                        mode_stat = cfg.oam_irq_enable;
                    end
                end
            end
            MS_OAM:
            begin
                if (count_sum >= OAM_CYCLES)
                begin
                    count_new = count_sum - OAM_CYCLES;
                    mode_new  = MS_TRANSFER;
                    mode_stat = cfg.oam_irq_enable;
                end
            end
            default:
            begin
                if (count_sum >= TRANSFER_CYCLES)
                begin
                    count_new = count_sum - TRANSFER_CYCLES;
                    mode_new  = MS_HBLANK;
                    draw      = 1'b1;
                    mode_stat = cfg.hblank_irq_enable;
                end
            end
        endcase
    end

    // The coincidence test uses the updated line.
    assign match = (line_new == cfg.line_compare);

    // A disabled display clears the state and gives an all-zero result.
    always_comb
    begin
        if (!cfg.display_enable)
        begin
            state_next.cycle_count = 8'd0;
            state_next.mode        = MS_HBLANK;
            state_next.line        = 8'd0;
            result                 = '0;
        end
        else
        begin
            state_next.cycle_count = count_new;
            state_next.mode        = mode_new;
            state_next.line        = line_new;
            result.disp_mode       = mode_code(mode_new);
            result.current_line    = line_new;
            result.line_match      = match;
            result.vblank_irq      = vbl;
            result.stat_irq        = mode_stat | (match & cfg.match_irq_enable);
            result.draw_line       = draw;
        end
    end

endmodule
